[hw/rtl/wies_pkg.sv]
// Shared types and constants for the information element scanner.
// Used by the interfaces, the parser core, the result register and the top level.
package wies_pkg;

    localparam int MAX_BUFFER_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int OFFSET_W         = 12;
    localparam int LENGTH_W         = 8;
    localparam int COUNT_W          = 12;

    localparam logic [7:0]         EID_SSID    = 8'd0;
    localparam logic [7:0]         EID_RATES   = 8'd1;
    localparam logic [7:0]         EID_DS      = 8'd3;
    localparam logic [COUNT_W-1:0] UNKNOWN_CAP = COUNT_W'(2048);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_FAILED  = 2'd2
    } status_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } record_t;

    typedef struct packed {
        status_t            parse_status;
        record_t            ssid;
        record_t            rates;
        record_t            ds;
        logic [COUNT_W-1:0] unknown_total;
    } result_t;

endpackage

[hw/rtl/wies_ifs.sv]
// Valid/ready channel interfaces for the information element scanner.
// Depends on wies_pkg for the field widths.
interface wies_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wies_result_if import wies_pkg::*;;
    logic                valid;
    logic                ready;
    logic [1:0]          parse_status;
    logic                ssid_found;
    logic [OFFSET_W-1:0] ssid_offset;
    logic [LENGTH_W-1:0] ssid_length;
    logic                rates_found;
    logic [OFFSET_W-1:0] rates_offset;
    logic [LENGTH_W-1:0] rates_length;
    logic                ds_found;
    logic [OFFSET_W-1:0] ds_offset;
    logic [LENGTH_W-1:0] ds_length;
    logic [COUNT_W-1:0]  unknown_total;

    modport source (
        output valid, output parse_status,
        output ssid_found, output ssid_offset, output ssid_length,
        output rates_found, output rates_offset, output rates_length,
        output ds_found, output ds_offset, output ds_length,
        output unknown_total, input ready
    );
    modport sink (
        input valid, input parse_status,
        input ssid_found, input ssid_offset, input ssid_length,
        input rates_found, input rates_offset, input rates_length,
        input ds_found, input ds_offset, input ds_length,
        input unknown_total, output ready
    );
endinterface

[hw/rtl/wifi_info_element_scanner.sv]
// Top level of the 802.11 information element scanner.
// Depends on wies_pkg, the channel interfaces, wies_core and wies_out_reg.
//
// The frame channel carries the frame body one byte per item, the final byte of
// each buffer marked by last_byte. The report channel carries one item per
// buffer: the parse status, the SSID, supported rates and DS parameter records
// (offset and length of each value) and the saturating unknown element count.
// A byte is taken in every cycle in which the frame channel is valid and the
// block is ready, so the throughput is one byte per cycle. The report appears
// on the report channel in the cycle after the final byte is accepted.
// The report sits in a single result register; while the receiver stalls it
// holds there, and further bytes are still accepted until another final byte
// arrives, which waits until the held report is taken.
// After the final byte the parse state returns to its reset values, ready for
// the next buffer. Reset clears the parse state and empties the result register.
// Bytes beyond the buffer limit are ignored and make the status failed.
module wifi_info_element_scanner import wies_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wies_byte_if.sink   frame,
    wies_result_if.source report
);

    logic    slot_free;
    logic    accept;
    logic    out_valid;
    result_t result;
    result_t held;

    assign frame.ready = slot_free || !frame.last_byte;
    assign accept      = frame.valid && frame.ready;

    wies_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (frame.data_byte),
        .last_byte (frame.last_byte),
        .result    (result)
    );

    wies_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && frame.last_byte),
        .result (result),
        .ready  (slot_free),
        .valid  (out_valid),
        .taken  (report.ready),
        .held   (held)
    );

    assign report.valid         = out_valid;
    assign report.parse_status  = held.parse_status;
    assign report.ssid_found    = held.ssid.found;
    assign report.ssid_offset   = held.ssid.offset;
    assign report.ssid_length   = held.ssid.length;
    assign report.rates_found   = held.rates.found;
    assign report.rates_offset  = held.rates.offset;
    assign report.rates_length  = held.rates.length;
    assign report.ds_found      = held.ds.found;
    assign report.ds_offset     = held.ds.offset;
    assign report.ds_length     = held.ds.length;
    assign report.unknown_total = held.unknown_total;

endmodule

[hw/rtl/wies_core.sv]
// Per-byte element walker: holds the parse state and forms the result for the final byte.
// Depends on wies_pkg.
module wies_core import wies_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    result
);

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         element_id_reg, element_id_next;
    logic [7:0]         elem_len_reg, elem_len_next;
    logic [7:0]         body_left_reg, body_left_next;
    logic [POS_W-1:0]   position_reg, position_next;
    record_t            ssid_reg, ssid_next;
    record_t            rates_reg, rates_next;
    record_t            ds_reg, ds_next;
    logic [COUNT_W-1:0] unknown_reg, unknown_next;
    logic               overflow_reg, overflow_next;

    logic               finish;
    logic [7:0]         finish_len;
    record_t            finished;
    status_t            status;

    always_comb
    begin
        phase_next      = phase_reg;
        element_id_next = element_id_reg;
        elem_len_next   = elem_len_reg;
        body_left_next  = body_left_reg;
        position_next   = position_reg;
        overflow_next   = overflow_reg;
        finish          = 1'b0;
        finish_len      = elem_len_reg;

        if (!overflow_reg)
        begin
            if (position_reg >= POS_W'(MAX_BUFFER_BYTES))
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ID:
                    begin
                        element_id_next = data_byte;
                        phase_next      = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        elem_len_next = data_byte;
                        finish_len    = data_byte;
                        if (data_byte == 8'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            body_left_next = data_byte;
                            phase_next     = PH_BODY;
                        end
                    end
                    default:
                    begin
                        body_left_next = body_left_reg - 8'd1;
                        if (body_left_next == 8'd0)
                        begin
                            finish = 1'b1;
                        end
                    end
                endcase
                position_next = position_reg + POS_W'(1);
            end
        end

        if (finish)
        begin
            phase_next = PH_ID;
        end

        finished.found  = 1'b1;
        finished.length = finish_len;
        finished.offset = OFFSET_W'(position_reg) + OFFSET_W'(1) - OFFSET_W'(finish_len);

        ssid_next    = ssid_reg;
        rates_next   = rates_reg;
        ds_next      = ds_reg;
        unknown_next = unknown_reg;
        if (finish)
        begin
            unique case (element_id_next)
                EID_SSID:  ssid_next  = finished;
                EID_RATES: rates_next = finished;
                EID_DS:    ds_next    = finished;
                default:
                begin
                    if (unknown_reg < UNKNOWN_CAP)
                    begin
                        unknown_next = unknown_reg + COUNT_W'(1);
                    end
                end
            endcase
        end

        if (overflow_next || phase_next != PH_ID)
        begin
            status = STATUS_FAILED;
        end
        else if (unknown_next != '0)
        begin
            status = STATUS_UNKNOWN;
        end
        else
        begin
            status = STATUS_OK;
        end

        result.parse_status  = status;
        result.ssid          = ssid_next;
        result.rates         = rates_next;
        result.ds            = ds_next;
        result.unknown_total = unknown_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ID;
            element_id_reg <= '0;
            elem_len_reg   <= '0;
            body_left_reg  <= '0;
            position_reg   <= '0;
            ssid_reg       <= '0;
            rates_reg      <= '0;
            ds_reg         <= '0;
            unknown_reg    <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg      <= PH_ID;
                element_id_reg <= '0;
                elem_len_reg   <= '0;
                body_left_reg  <= '0;
                position_reg   <= '0;
                ssid_reg       <= '0;
                rates_reg      <= '0;
                ds_reg         <= '0;
                unknown_reg    <= '0;
                overflow_reg   <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                element_id_reg <= element_id_next;
                elem_len_reg   <= elem_len_next;
                body_left_reg  <= body_left_next;
                position_reg   <= position_next;
                ssid_reg       <= ssid_next;
                rates_reg      <= rates_next;
                ds_reg         <= ds_next;
                unknown_reg    <= unknown_next;
                overflow_reg   <= overflow_next;
            end
        end
    end

    // The position stops at the buffer limit, and the overflow flag is only set there.
    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_W'(MAX_BUFFER_BYTES))
        else $error("byte position passed the buffer limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> position_reg == POS_W'(MAX_BUFFER_BYTES))
        else $error("overflow set before the buffer limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> body_left_reg != 8'd0)
        else $error("value phase with no bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        unknown_reg <= UNKNOWN_CAP)
        else $error("unknown count passed its cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> position_reg == '0 && phase_reg == PH_ID)
        else $error("state not cleared after the final byte");

endmodule

[hw/rtl/wies_out_reg.sv]
// Result register that parts the byte input from a stalled result receiver.
// Depends on wies_pkg.
module wies_out_reg import wies_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    ready,
    output logic    valid,
    input  logic    taken,
    output result_t held
);

    logic    valid_reg;
    result_t data_reg;

    assign ready = !valid_reg || taken;
    assign valid = valid_reg;
    assign held  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("result loaded over one not yet taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not shown");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !taken && !load |=> valid_reg && $stable(data_reg))
        else $error("waiting result lost or changed");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wifi_info_element_scanner: drives frame bodies byte by byte
// and checks each buffer's report against a behavioural model of the element walk.
// Depends on wies_pkg, the channel interfaces in wies_ifs.sv and the scanner RTL.
module tb_top;
    import wies_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        LONG_UNKNOWN_FILL,
        LONG_OFFSET_WRAP,
        LONG_OVERFLOW,
        LONG_WELL_FORMED
    } long_frame_t;

    // Model of the scanner: walks the elements of each buffer and queues the report that
    // the final byte should produce.
    class ie_report_tracker;
        typedef enum logic [1:0] {AWAIT_ID, AWAIT_LEN, IN_VALUE} scan_phase_t;

        scan_phase_t        phase;
        logic [7:0]         elem_id;
        logic [7:0]         elem_len;
        logic [7:0]         value_left;
        int unsigned        position;
        record_t            ssid_rec;
        record_t            rates_rec;
        record_t            ds_rec;
        logic [COUNT_W-1:0] unknown_cnt;
        bit                 overflowed;
        result_t            expected_reports[$];
        int unsigned        failures;

        function new();
            clear_scan();
            failures = 0;
        endfunction

        function void clear_scan();
            phase       = AWAIT_ID;
            elem_id     = '0;
            elem_len    = '0;
            value_left  = '0;
            position    = 0;
            ssid_rec    = '0;
            rates_rec   = '0;
            ds_rec      = '0;
            unknown_cnt = '0;
            overflowed  = 1'b0;
        endfunction

        function void close_element(int unsigned value_end);
            record_t rec;
            rec.found  = 1'b1;
            rec.offset = OFFSET_W'(value_end - elem_len);
            rec.length = elem_len;
            case (elem_id)
                EID_SSID:  ssid_rec = rec;
                EID_RATES: rates_rec = rec;
                EID_DS:    ds_rec = rec;
                default:
                begin
                    if (unknown_cnt < UNKNOWN_CAP)
                    begin
                        unknown_cnt++;
                    end
                end
            endcase
            phase = AWAIT_ID;
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            result_t rep;
            if (!overflowed)
            begin
                if (position >= MAX_BUFFER_BYTES)
                begin
                    overflowed = 1'b1;
                end
                else
                begin
                    case (phase)
                        AWAIT_ID:
                        begin
                            elem_id = data;
                            phase   = AWAIT_LEN;
                        end
                        AWAIT_LEN:
                        begin
                            elem_len = data;
                            if (data == 8'd0)
                            begin
                                close_element(position + 1);
                            end
                            else
                            begin
                                value_left = data;
                                phase      = IN_VALUE;
                            end
                        end
                        default:
                        begin
                            value_left--;
                            if (value_left == 8'd0)
                            begin
                                close_element(position + 1);
                            end
                        end
                    endcase
                    position++;
                end
            end
            if (last)
            begin
                if (overflowed || phase != AWAIT_ID)
                begin
                    rep.parse_status = STATUS_FAILED;
                end
                else if (unknown_cnt != '0)
                begin
                    rep.parse_status = STATUS_UNKNOWN;
                end
                else
                begin
                    rep.parse_status = STATUS_OK;
                end
                rep.ssid          = ssid_rec;
                rep.rates         = rates_rec;
                rep.ds            = ds_rec;
                rep.unknown_total = unknown_cnt;
                expected_reports.push_back(rep);
                clear_scan();
            end
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void compare_field(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                note_failure($sformatf("%s mismatch: expected %0d, actual %0d",
                                       field, want, got));
            end
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (expected_reports.size() == 0)
            begin
                note_failure($sformatf("report with no buffer outstanding, status %0d",
                                       got.parse_status));
                return;
            end
            want = expected_reports.pop_front();
            compare_field("parse_status", 12'(want.parse_status), 12'(got.parse_status));
            compare_field("ssid_found", 12'(want.ssid.found), 12'(got.ssid.found));
            compare_field("ssid_offset", 12'(want.ssid.offset), 12'(got.ssid.offset));
            compare_field("ssid_length", 12'(want.ssid.length), 12'(got.ssid.length));
            compare_field("rates_found", 12'(want.rates.found), 12'(got.rates.found));
            compare_field("rates_offset", 12'(want.rates.offset), 12'(got.rates.offset));
            compare_field("rates_length", 12'(want.rates.length), 12'(got.rates.length));
            compare_field("ds_found", 12'(want.ds.found), 12'(got.ds.found));
            compare_field("ds_offset", 12'(want.ds.offset), 12'(got.ds.offset));
            compare_field("ds_length", 12'(want.ds.length), 12'(got.ds.length));
            compare_field("unknown_total", 12'(want.unknown_total), 12'(got.unknown_total));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic rx_hold;
    logic start_hold = 1'b0;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   bytes_sent;
    int   cycle_count = 0;

    logic [7:0] frame_bytes[$];
    ie_report_tracker tracker = new();

    wies_byte_if   frame_ch();
    wies_result_if report_ch();

    wifi_info_element_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .report (report_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** wifi_info_element_scanner: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        report_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        rx_hold = 1'b0;
        wait (start_hold);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            tracker.note_byte(frame_ch.data_byte, frame_ch.last_byte);
        end
    end

    always @(posedge clk)
    begin : report_monitor
        result_t got;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            got.parse_status  = status_t'(report_ch.parse_status);
            got.ssid.found    = report_ch.ssid_found;
            got.ssid.offset   = report_ch.ssid_offset;
            got.ssid.length   = report_ch.ssid_length;
            got.rates.found   = report_ch.rates_found;
            got.rates.offset  = report_ch.rates_offset;
            got.rates.length  = report_ch.rates_length;
            got.ds.found      = report_ch.ds_found;
            got.ds.offset     = report_ch.ds_offset;
            got.ds.length     = report_ch.ds_length;
            got.unknown_total = report_ch.unknown_total;
            tracker.check_report(got);
        end
    end

    function automatic logic [7:0] pick_id();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
        begin
            return EID_SSID;
        end
        if (sel < 4)
        begin
            return EID_RATES;
        end
        if (sel < 6)
        begin
            return EID_DS;
        end
        return 8'($urandom);
    endfunction

    function automatic void push_element(logic [7:0] id, logic [7:0] len);
        frame_bytes.push_back(id);
        frame_bytes.push_back(len);
        for (int i = 0; i < len; i++)
        begin
            frame_bytes.push_back(8'($urandom));
        end
    endfunction

    // Mostly well-formed element lists with random content; the rest is noise, cut short
    // or carries one stray trailing byte.
    task automatic build_random_frame();
        int n_elems;
        int flavour;
        int cut;
        frame_bytes.delete();
        n_elems = $urandom_range(5);
        for (int i = 0; i < n_elems; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                push_element(pick_id(), 8'($urandom_range(255)));
            end
            else
            begin
                push_element(pick_id(), 8'($urandom_range(8)));
            end
        end
        flavour = $urandom_range(9);
        if (flavour == 0)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
        end
        else if (flavour == 1 && frame_bytes.size() > 1)
        begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
        else if (flavour == 2)
        begin
            frame_bytes.push_back(8'($urandom));
        end
        if (frame_bytes.size() == 0)
        begin
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_long_frame(long_frame_t kind);
        logic [7:0] id;
        int         fill_to;
        frame_bytes.delete();
        if (kind == LONG_UNKNOWN_FILL || kind == LONG_OFFSET_WRAP)
        begin
            for (int n = 0; n < MAX_BUFFER_BYTES / 2; n++)
            begin
                do
                begin
                    id = 8'($urandom);
                end
                while (id == EID_SSID || id == EID_RATES || id == EID_DS);
                if (kind == LONG_OFFSET_WRAP && n == MAX_BUFFER_BYTES / 2 - 1)
                begin
                    id = EID_SSID;
                end
                frame_bytes.push_back(id);
                frame_bytes.push_back(8'd0);
            end
        end
        else
        begin
            fill_to = (kind == LONG_OVERFLOW) ? MAX_BUFFER_BYTES + 4 : MAX_BUFFER_BYTES - 257;
            while (frame_bytes.size() < fill_to)
            begin
                push_element(pick_id(), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                frame_ch.valid <= 1'b0;
                @(posedge clk);
            end
            frame_ch.valid     <= 1'b1;
            frame_ch.data_byte <= frame_bytes[i];
            frame_ch.last_byte <= (i == frame_bytes.size() - 1);
            @(posedge clk);
            while (!frame_ch.ready)
            begin
                @(posedge clk);
            end
            bytes_sent++;
        end
    endtask

    task automatic send_random_until(int target);
        while (bytes_sent < target)
        begin
            build_random_frame();
            send_frame();
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        frame_ch.valid     = 1'b0;
        frame_ch.data_byte = 8'd0;
        frame_ch.last_byte = 1'b0;
        bytes_sent         = 0;
        tx_idle_pct        = 13;
        rx_idle_pct        = 72;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone id byte, then a value overwritten by a zero-length element of the same id.
        frame_bytes = '{8'h00};
        send_frame();
        frame_bytes = '{EID_SSID, 8'd2, 8'h41, 8'h42, EID_SSID, 8'd0};
        send_frame();
        frame_bytes = '{EID_RATES, 8'd2, 8'hFF, 8'h00, EID_DS, 8'd1, 8'h80,
                        8'd221, 8'd1, 8'h7F};
        send_frame();
        // A stray trailing byte, then a buffer that ends inside a value.
        frame_bytes = '{EID_DS, 8'd1, 8'h0B, 8'hC3};
        send_frame();
        frame_bytes = '{EID_RATES, 8'd5, 8'h01};
        send_frame();

        send_random_until(300);
        build_long_frame(LONG_UNKNOWN_FILL);
        send_frame();
        build_long_frame(LONG_OFFSET_WRAP);
        send_frame();

        tx_idle_pct = 72;
        rx_idle_pct = 13;
        send_random_until(bytes_sent + 300);
        build_long_frame(LONG_OVERFLOW);
        send_frame();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        start_hold <= 1'b1;
        send_random_until(bytes_sent + 300);
        build_long_frame(LONG_WELL_FORMED);
        send_frame();
        frame_ch.valid <= 1'b0;

        while (tracker.expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
        begin
            $display("** wifi_info_element_scanner: PASSED **");
        end
        else
        begin
            $display("** wifi_info_element_scanner: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wies_pkg.sv
hw/rtl/wies_ifs.sv
hw/rtl/wies_core.sv
hw/rtl/wies_out_reg.sv
hw/rtl/wifi_info_element_scanner.sv
tb/sv/tb_top.sv
